### sv/keyed_record_table_macros.svh
// Assertion macros used by the checker file.
// Both sample on clk and are disabled while arst_n is low.
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication.
`define KRT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed_record_table: same-cycle check failed");

// Next-cycle implication.
`define KRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed_record_table: next-cycle check failed");

`endif

### sv/krt_pkg.sv
package krt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int ROW_W    = 6;
	localparam int COUNT_W  = 7;
	localparam int KIND_W   = 2;

	// stream payload widths
	localparam int IN_FIELDS_W = ROW_W + 2 * KEY_W + HANDLE_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = 1 + HANDLE_W + COUNT_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_GET    = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GET,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// table RAM access from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// finished result offered to the output register
	typedef struct packed {
		logic                valid;
		logic                success;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  count;
	} res_t;

endpackage

### sv/keyed_record_table.sv
// Ordered table of up to 64 (record id, handle) rows serving one request at a
// time: get by row, add (rejects a present id or a full table), update by id,
// and remove by id with the later rows moved down in order. Each request gives
// one result with success, the handle read by a get (zero otherwise) and the
// row count after the request. All rows live in one RAM with one read and one
// write port, so a request walks it one row per cycle: a get reads its row if
// in range, add and update scan the ids, and a remove that hits a row then
// moves the later rows down in a second pass. s_tready is low from acceptance
// until the result is handed to the output register; a result may wait there
// while the next request is taken.
module keyed_record_table import krt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// row_index[5:0], search_key[37:6], record_key[69:38],
	// record_handle[85:70], zero pad[87:86]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [KIND_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// success[0], found_handle[16:1], row_count[23:17]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	ram_req_t               ram_req;
	logic [ENTRY_W-1:0]     ram_rdata;
	res_t                   res;
	logic                   res_take;
	logic                   m_tvalid_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;

	krt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	krt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (kind_t'(s_tuser)),
		.in_row     (s_tdata[ROW_W-1:0]),
		.in_skey    (s_tdata[ROW_W +: KEY_W]),
		.in_rkey    (s_tdata[ROW_W + KEY_W +: KEY_W]),
		.in_rhandle (s_tdata[ROW_W + 2 * KEY_W +: HANDLE_W]),
		.ram_rdata  (entry_t'(ram_rdata)),
		.ram_req    (ram_req),
		.res        (res),
		.res_take   (res_take)
	);

	// output register takes a result whenever its slot is free
	assign res_take = res.valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= {res.count, res.handle, res.success};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### sv/krt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module krt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/krt_ctrl.sv
// Request sequencer: one shared key comparator walks the table RAM,
// one read per cycle, and a second pass moves rows down on remove.
module krt_ctrl import krt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kind_t               in_kind,
	input  logic [ROW_W-1:0]    in_row,
	input  logic [KEY_W-1:0]    in_skey,
	input  logic [KEY_W-1:0]    in_rkey,
	input  logic [HANDLE_W-1:0] in_rhandle,
	input  entry_t              ram_rdata,
	output ram_req_t            ram_req,
	output res_t                res,
	input  logic                res_take
);

	state_t state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    idx_q, idx_d;
	logic                chk_v_s1, chk_v_d;
	logic [ADDR_W-1:0]   chk_idx_s1, chk_idx_d;
	kind_t               kind_q, kind_d;
	logic [KEY_W-1:0]    key_q, key_d;
	entry_t              rec_q, rec_d;
	logic                ok_q, ok_d;
	logic [HANDLE_W-1:0] handle_q, handle_d;
	logic                match;

	// the shared comparator
	assign match = chk_v_s1 && (ram_rdata.key == key_q);

	// next state, RAM requests and result
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		chk_v_d   = chk_v_s1;
		chk_idx_d = chk_idx_s1;
		kind_d    = kind_q;
		key_d     = key_q;
		rec_d     = rec_q;
		ok_d      = ok_q;
		handle_d  = handle_q;
		ram_req   = '{we: 1'b0, waddr: chk_idx_s1, wdata: rec_q,
			raddr: idx_q[ADDR_W-1:0]};
		in_ready  = (state_q == ST_IDLE);
		res       = '{valid: (state_q == ST_DONE), success: ok_q, handle: handle_q,
			count: COUNT_W'(count_q)};

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_d     = in_kind;
					key_d      = (in_kind == KIND_ADD) ? in_rkey : in_skey;
					rec_d      = '{key: in_rkey, handle: in_rhandle};
					ok_d       = 1'b0;
					handle_d   = '0;
					idx_d      = '0;
					chk_v_d    = 1'b0;
					ram_req.raddr = in_row;
					if (in_kind == KIND_GET) begin
						state_d = ({1'b0, in_row} < CNT_W'(count_q)) ? ST_GET : ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_GET: begin
				ok_d     = 1'b1;
				handle_d = ram_rdata.handle;
				state_d  = ST_DONE;
			end
			ST_SCAN: begin
				if (match) begin
					case (kind_q)
						KIND_UPDATE: begin
							ram_req.we    = 1'b1;
							ram_req.waddr = chk_idx_s1;
							ok_d          = 1'b1;
							state_d       = ST_DONE;
						end
						KIND_REMOVE: begin
							idx_d   = {1'b0, chk_idx_s1} + CNT_W'(1);
							chk_v_d = 1'b0;
							state_d = ST_SHIFT;
						end
						default: begin
							// add of an id already present
							state_d = ST_DONE;
						end
					endcase
				end else if (idx_q < count_q) begin
					ram_req.raddr = idx_q[ADDR_W-1:0];
					chk_v_d       = 1'b1;
					chk_idx_d     = idx_q[ADDR_W-1:0];
					idx_d         = idx_q + CNT_W'(1);
				end else if (!chk_v_s1) begin
					// whole table checked, no match
					if (kind_q == KIND_ADD && count_q < CNT_W'(TABLE_DEPTH)) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = count_q[ADDR_W-1:0];
						count_d       = count_q + CNT_W'(1);
						ok_d          = 1'b1;
					end
					state_d = ST_DONE;
				end else begin
					chk_v_d = 1'b0;
				end
			end
			ST_SHIFT: begin
				// row read last cycle lands one place lower
				ram_req.wdata = ram_rdata;
				ram_req.waddr = chk_idx_s1;
				ram_req.we    = chk_v_s1;
				if (idx_q < count_q) begin
					ram_req.raddr = idx_q[ADDR_W-1:0];
					chk_v_d       = 1'b1;
					chk_idx_d     = idx_q[ADDR_W-1:0] - ADDR_W'(1);
					idx_d         = idx_q + CNT_W'(1);
				end else if (!chk_v_s1) begin
					count_d = count_q - CNT_W'(1);
					ok_d    = 1'b1;
					state_d = ST_DONE;
				end else begin
					chk_v_d = 1'b0;
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			chk_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			chk_v_s1 <= chk_v_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		chk_idx_s1 <= chk_idx_d;
		kind_q     <= kind_d;
		key_q      <= key_d;
		rec_q      <= rec_d;
		ok_q       <= ok_d;
		handle_q   <= handle_d;
	end

endmodule

### sv/krt_checker.sv
`include "keyed_record_table_macros.svh"

// Port-level checks on the keyed record table.
module krt_checker import krt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic [KIND_W-1:0]     s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// a stalled result holds
	`KRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// the block is busy right after taking an item
	`KRT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

	// row count never passes the table depth
	`KRT_ASSERT_NOW(a_count_range, m_tvalid, m_tdata[OUT_DATA_W-1:1+HANDLE_W] <= COUNT_W'(TABLE_DEPTH))

	// a failed request never returns a handle
	`KRT_ASSERT_NOW(a_fail_no_handle, m_tvalid && !m_tdata[0], m_tdata[HANDLE_W:1] == '0)

endmodule

bind keyed_record_table krt_checker u_krt_checker (.*);
